/* rtl/pbcm_pkg.sv */
// Package for the page buffer clock manager.
// Request modes, status codes, payload structs, the queue entry type and the back-end states.
// Depends on nothing.
package pbcm_pkg;

	typedef enum logic [2:0] {
		MODE_READ    = 3'd0,
		MODE_UNPIN   = 3'd1,
		MODE_ALLOC   = 3'd2,
		MODE_DISPOSE = 3'd3,
		MODE_FLUSH   = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_ALL_PINNED  = 3'd1,
		ST_NOT_RES     = 3'd2,
		ST_NOT_PINNED  = 3'd3,
		ST_PAGE_PINNED = 3'd4,
		ST_ALREADY_RES = 3'd5
	} status_t;

	localparam logic [7:0] PIN_MAX = 8'd255;
	localparam logic [4:0] CFG_RESET = 5'd16;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  file_id;
		logic [23:0] page_no;
		logic        mark_dirty;
		logic        known;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  frame_index;
		logic        writeback;
		logic [7:0]  writeback_file;
		logic [23:0] writeback_page;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_LOOK,
		EX_CLAIM,
		EX_FLUSH,
		EX_EMIT
	} ex_state_t;

endpackage

/* rtl/pbcm_front.sv */
// Front end: accepts requests, decodes the mode and queues commands.
// Uses pbcm_pkg. Two-entry queue parts the input from the back end.
module pbcm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [35:0]     in_data,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output pbcm_pkg::cmd_t  cmd
);
	import pbcm_pkg::*;

	cmd_t       q_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	cmd_t       dec;

	always_comb begin
		dec.mode       = in_data[2:0];
		dec.file_id    = in_data[10:3];
		dec.page_no    = in_data[34:11];
		dec.mark_dirty = in_data[35];
		dec.known      = (in_data[2:0] == MODE_READ) || (in_data[2:0] == MODE_UNPIN) ||
			(in_data[2:0] == MODE_ALLOC) || (in_data[2:0] == MODE_DISPOSE) ||
			(in_data[2:0] == MODE_FLUSH);
	end

	assign in_ready  = cnt_q != 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) q_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (cmd_valid && cmd_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overfill");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ready) else $error("accept while full");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !cmd_valid) else $error("pop from empty");
endmodule

/* rtl/pbcm_back.sv */
// Back end: frame table, lookup scan, clock sweep and flush walk. Uses pbcm_pkg.
// One frame per cycle; a flush waits while the one-entry result register is full.
module pbcm_back #(
	parameter int NUM_FRAMES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  pbcm_pkg::cmd_t  cmd,
	input  logic            cfg_we,
	input  logic [4:0]      cfg_wdata,
	output logic [4:0]      cfg_q,
	output logic            res_valid,
	input  logic            res_ready,
	output pbcm_pkg::res_t  res
);
	import pbcm_pkg::*;

	localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

	logic         valid_q [NUM_FRAMES];
	logic [7:0]   pins_q  [NUM_FRAMES];
	logic         ref_q   [NUM_FRAMES];
	logic         dirty_q [NUM_FRAMES];
	logic [7:0]   file_q  [NUM_FRAMES];
	logic [23:0]  page_q  [NUM_FRAMES];

	ex_state_t    st_q, st_d;
	cmd_t         c_q;
	logic [IW-1:0] idx_q, hand_q, start_q, n_m1;
	logic         round_q;
	logic         ov_q;
	res_t         out_q, pend_q;
	logic [4:0]   cfg_val;
	logic [5:0]   nsize;

	always_comb begin
		if (cfg_q == 5'd0) nsize = 6'd1;
		else if ({1'b0, cfg_q} > 6'(NUM_FRAMES)) nsize = 6'(NUM_FRAMES);
		else nsize = {1'b0, cfg_q};
		n_m1 = IW'(nsize - 6'd1);
	end
	assign cfg_val = cfg_wdata;

	logic  hit, ok_out, fl_match, fl_pin, take, load_out;
	logic [IW-1:0] nxt;
	assign hit = valid_q[idx_q] && file_q[idx_q] == c_q.file_id && page_q[idx_q] == c_q.page_no;
	assign ok_out = !ov_q || res_ready;
	assign res_valid = ov_q;
	assign res = out_q;
	assign cmd_ready = st_q == EX_IDLE;
	assign nxt = (hand_q == n_m1) ? '0 : hand_q + IW'(1);
	assign fl_match = valid_q[idx_q] && file_q[idx_q] == c_q.file_id;
	assign fl_pin = fl_match && pins_q[idx_q] != 8'd0;
	assign take = !valid_q[nxt] || (!ref_q[nxt] && pins_q[nxt] == 8'd0);

	function automatic res_t mk(logic [2:0] s, logic [3:0] f);
		res_t r;
		r = '0;
		r.status = s; r.frame_index = f; r.last = 1'b1;
		return r;
	endfunction

	always_comb begin
		st_d = st_q;
		load_out = 1'b0;
		case (st_q)
			EX_IDLE: if (cmd_valid) begin
				if (!cmd.known) st_d = EX_EMIT;
				else st_d = (cmd.mode == MODE_FLUSH) ? EX_FLUSH : EX_LOOK;
			end
			EX_LOOK: begin
				if (hit) st_d = EX_EMIT;
				else if (idx_q == n_m1)
					st_d = (c_q.mode == MODE_UNPIN || c_q.mode == MODE_DISPOSE) ? EX_EMIT : EX_CLAIM;
			end
			EX_CLAIM: begin
				if ((nxt == start_q && round_q) || take) st_d = EX_EMIT;
			end
			EX_FLUSH: if (ok_out) begin
				if (fl_pin || idx_q == n_m1) st_d = EX_EMIT;
				load_out = fl_match && !fl_pin && dirty_q[idx_q];
			end
			EX_EMIT: if (ok_out) begin
				st_d = EX_IDLE;
				load_out = 1'b1;
			end
			default: st_d = EX_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == EX_IDLE && cmd_valid) c_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= EX_IDLE; ov_q <= 1'b0; cfg_q <= CFG_RESET;
			hand_q <= IW'(NUM_FRAMES - 1); idx_q <= '0; start_q <= '0; round_q <= 1'b0;
			out_q <= '0; pend_q <= '0;
			for (int i = 0; i < NUM_FRAMES; i++) begin
				valid_q[i] <= 1'b0; pins_q[i] <= '0; ref_q[i] <= 1'b0;
				dirty_q[i] <= 1'b0; file_q[i] <= '0; page_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (load_out) ov_q <= 1'b1;
			else if (res_ready) ov_q <= 1'b0;
			if (cfg_we) begin
				cfg_q <= cfg_val;
				hand_q <= (cfg_val == 5'd0) ? '0 :
					({1'b0, cfg_val} > 6'(NUM_FRAMES)) ? IW'(NUM_FRAMES - 1) :
					IW'(cfg_val - 5'd1);
				for (int i = 0; i < NUM_FRAMES; i++) begin
					valid_q[i] <= 1'b0; pins_q[i] <= '0; ref_q[i] <= 1'b0;
					dirty_q[i] <= 1'b0; file_q[i] <= '0; page_q[i] <= '0;
				end
			end
			case (st_q)
				EX_IDLE: if (cmd_valid) begin
					idx_q <= '0;
					if (!cmd.known) pend_q <= mk(ST_OK, 4'd0);
				end
				EX_LOOK: begin
					if (hit) begin
						case (c_q.mode)
							MODE_READ: begin
								ref_q[idx_q] <= 1'b1;
								if (pins_q[idx_q] != PIN_MAX) pins_q[idx_q] <= pins_q[idx_q] + 8'd1;
								pend_q <= mk(ST_OK, 4'(idx_q));
							end
							MODE_ALLOC: pend_q <= mk(ST_ALREADY_RES, 4'(idx_q));
							MODE_UNPIN: begin
								if (pins_q[idx_q] == 8'd0) pend_q <= mk(ST_NOT_PINNED, 4'(idx_q));
								else begin
									pins_q[idx_q] <= pins_q[idx_q] - 8'd1;
									if (c_q.mark_dirty) dirty_q[idx_q] <= 1'b1;
									pend_q <= mk(ST_OK, 4'(idx_q));
								end
							end
							default: begin
								valid_q[idx_q] <= 1'b0; pins_q[idx_q] <= '0; ref_q[idx_q] <= 1'b0;
								dirty_q[idx_q] <= 1'b0; file_q[idx_q] <= '0; page_q[idx_q] <= '0;
								pend_q <= mk(ST_OK, 4'(idx_q));
							end
						endcase
					end else if (idx_q == n_m1) begin
						case (c_q.mode)
							MODE_UNPIN: pend_q <= mk(ST_NOT_RES, 4'd0);
							MODE_DISPOSE: pend_q <= mk(ST_OK, 4'd0);
							default: begin start_q <= hand_q; round_q <= 1'b0; end
						endcase
					end else idx_q <= idx_q + IW'(1);
				end
				EX_CLAIM: begin
					hand_q <= nxt;
					if (nxt == start_q && round_q) begin
						pend_q <= mk(ST_ALL_PINNED, 4'd0);
					end else begin
						if (nxt == start_q) round_q <= 1'b1;
						if (ref_q[nxt] && valid_q[nxt]) ref_q[nxt] <= 1'b0;
						else if (take) begin
							pend_q <= '{status: ST_OK, frame_index: 4'(nxt),
								writeback: valid_q[nxt] && dirty_q[nxt],
								writeback_file: (valid_q[nxt] && dirty_q[nxt]) ? file_q[nxt] : 8'd0,
								writeback_page: (valid_q[nxt] && dirty_q[nxt]) ? page_q[nxt] : 24'd0,
								last: 1'b1};
							valid_q[nxt] <= 1'b1; pins_q[nxt] <= 8'd1; ref_q[nxt] <= 1'b1;
							dirty_q[nxt] <= 1'b0; file_q[nxt] <= c_q.file_id;
							page_q[nxt] <= c_q.page_no;
						end
					end
				end
				EX_FLUSH: if (ok_out) begin
					if (fl_pin) begin
						pend_q <= mk(ST_PAGE_PINNED, 4'(idx_q));
					end else begin
						if (fl_match) begin
							if (dirty_q[idx_q]) begin
								out_q <= '{status: ST_OK, frame_index: 4'(idx_q), writeback: 1'b1,
									writeback_file: file_q[idx_q], writeback_page: page_q[idx_q],
									last: 1'b0};
							end
							valid_q[idx_q] <= 1'b0; pins_q[idx_q] <= '0; ref_q[idx_q] <= 1'b0;
							dirty_q[idx_q] <= 1'b0; file_q[idx_q] <= '0; page_q[idx_q] <= '0;
						end
						if (idx_q == n_m1) pend_q <= mk(ST_OK, 4'd0);
						else idx_q <= idx_q + IW'(1);
					end
				end
				EX_EMIT: if (ok_out) out_q <= pend_q;
				default: ;
			endcase
		end
	end

	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == EX_FLUSH |-> idx_q <= n_m1) else $error("flush index past pool");
	a_hand: assert property (@(posedge clk) disable iff (!arst_n)
		hand_q <= n_m1) else $error("hand past pool");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !res_ready |=> ov_q && $stable(out_q)) else $error("result lost");
endmodule

/* rtl/page_buffer_clock_manager_top.sv */
// Path of a request, n frames in use: dispatch, lookup scan over the n frames, clock sweep, emit;
// a flush walks the n frames, stops at a pinned page of its file and stalls on each waiting write-back.
// Throughput: one request in the back end at a time; a two-entry queue takes further requests
// meanwhile.
// Reset (arst_n low) clears every frame, sets frames_in_use to 16 and the hand to NUM_FRAMES-1.
// A frames_in_use write clears the pool in the same cycle; a request in flight may still write its frame then.
module page_buffer_clock_manager_top #(
	parameter int NUM_FRAMES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // mode, file_id, page_no, mark_dirty
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // status, frame_index, writeback, writeback_file, writeback_page
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pbcm_pkg::*;

	logic cmd_valid, cmd_ready, cfg_we;
	cmd_t cmd;
	res_t res;
	logic [4:0] cfg_q;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && paddr == 2'd0;
	assign prdata = (paddr == 2'd0) ? {27'd0, cfg_q} : 32'd0;

	pbcm_front u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata[35:0]), .cmd_valid, .cmd_ready, .cmd
	);

	pbcm_back #(.NUM_FRAMES(NUM_FRAMES)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .cfg_we,
		.cfg_wdata(pwdata[4:0]), .cfg_q, .res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {res.writeback_page, res.writeback_file,
		res.writeback, res.frame_index, res.status};
	assign m_axis_tlast = res.last;
endmodule
